// ----- sv/ugbs_pkg.sv -----
// ----------------------------------------------------------------------------
// ugbs_pkg: shared types and constants of the uniform grid bucket store
// command codes, status codes and register indexes
// ----------------------------------------------------------------------------
`default_nettype none
package ugbs_pkg;
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_COUNT  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] REG_CELL_SIZE = 2'd0;
    localparam logic [1:0] REG_COLUMNS   = 2'd1;
    localparam logic [1:0] REG_ROWS      = 2'd2;
    // index with no register behind it
    localparam logic [1:0] REG_SPARE     = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic        kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] object_id;
        logic [15:0] grid_col;
        logic [15:0] grid_row;
    } item_t;

    typedef struct packed {
        logic [15:0] stored_id;
        logic [4:0]  fill_count;
        logic [7:0]  cell_number;
        logic [1:0]  status;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [11:0] data;
    } cfg_t;

    // divider control
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [11:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

// ----- sv/ugbs_if.sv -----
// ----------------------------------------------------------------------------
// ugbs_if: valid/ready channel carrying one payload
// generic over the payload type
// ----------------------------------------------------------------------------
`default_nettype none
interface ugbs_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- sv/ugbs_ram.sv -----
// ----------------------------------------------------------------------------
// ugbs_ram: generic single-port ram
// one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module ugbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- sv/ugbs_div.sv -----
// ----------------------------------------------------------------------------
// ugbs_div: shared floor divider
// restoring division, one quotient bit per cycle, floor for negative dividends
// ----------------------------------------------------------------------------
`default_nettype none
module ugbs_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ugbs_pkg::div_req_t req,
    output ugbs_pkg::div_rsp_t     rsp
);
    import ugbs_pkg::*;

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] q_reg, q_next;
    logic [12:0] r_reg, r_next;
    logic [11:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [12:0] trial;
    logic [12:0] rs;
    logic [15:0] mag;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        rs        = {r_reg[11:0], q_reg[15]};
        trial     = rs - {1'b0, d_reg};
        mag       = req.dividend[15] ? (~req.dividend + 16'd1) : req.dividend;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            // magnitude of -32768 is 0x8000, fine as unsigned
            q_next    = mag;
            r_next    = 13'd0;
            d_next    = (req.divisor == 12'd0) ? 12'd1 : req.divisor;
            neg_next  = req.dividend[15];
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd16)
            begin
                // floor for negative dividends: negate, and subtract one when a remainder is left
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                begin
                    q_next = (r_reg != 13'd0) ? (~q_reg) : (~q_reg + 16'd1);
                end
            end
            else
            begin
                cnt_next = cnt_reg + 5'd1;
                if (!trial[12])
                begin
                    r_next = trial;
                    q_next = {q_reg[14:0], 1'b1};
                end
                else
                begin
                    r_next = rs;
                    q_next = {q_reg[14:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign rsp = '{done: done_reg, quotient: q_reg};
endmodule
`default_nettype wire

// ----- sv/uniform_grid_bucket_store_top.sv -----
// ----------------------------------------------------------------------------
// uniform_grid_bucket_store_top: two-kind uniform grid of object buckets
// insert, query, count and clear over per-cell buckets held in ram
// ----------------------------------------------------------------------------
// sequence: insert runs two divides on the shared divider, then cell, fill
//   read, update unless full; query the same up to the fill read, then its results;
//   count skips the divides; clear sweeps 2*2^clog2(cells) fill addresses (512 by default)
// items: one at a time, the next taken the cycle after the last
//   result transfer; a query reads each next bucket entry only after the previous result is taken
// reset: same fill clearing pass after reset, cell_size 32, columns 16, rows 16
`default_nettype none
module uniform_grid_bucket_store_top #(
    parameter int MAX_COLUMNS  = 16,
    parameter int MAX_ROWS     = 16,
    parameter int BUCKET_DEPTH = 16,
    parameter int ID_WIDTH     = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ugbs_if.sink      cfg,
    ugbs_if.sink      in_ch,
    ugbs_if.source    out_ch
);
    import ugbs_pkg::*;

    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int NW    = $clog2(BUCKET_DEPTH + 1);
    localparam int AW    = CW + SW + 1;
    localparam int FAW   = CW + 1;

    // sequencer codes
    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIVX  = 4'd2;
    localparam logic [3:0] S_DIVY  = 4'd3;
    localparam logic [3:0] S_CELL  = 4'd4;
    localparam logic [3:0] S_FRD   = 4'd5;
    localparam logic [3:0] S_FWAIT = 4'd6;
    localparam logic [3:0] S_ACT   = 4'd7;
    localparam logic [3:0] S_QRD   = 4'd8;
    localparam logic [3:0] S_QWAIT = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_CLR   = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [11:0] cs_reg;
    logic [4:0]  cols_reg, rows_reg;
    item_t       it_reg, it_next;
    logic [15:0] qx_reg, qx_next;
    logic [CW-1:0] cell_reg, cell_next;
    logic [CW:0]   clr_reg, clr_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] k_reg, k_next;
    result_t     res_reg, res_next;
    logic        ov_reg, ov_next;
    logic        done_after_reg, done_after_next;

    div_req_t dreq;
    div_rsp_t drsp;

    // effective grid shape
    logic [8:0] nc, nr;
    always_comb
    begin
        nc = (cols_reg == 5'd0) ? 9'd1 : {4'd0, cols_reg};
        if (nc > 9'(MAX_COLUMNS)) nc = 9'(MAX_COLUMNS);
        nr = (rows_reg == 5'd0) ? 9'd1 : {4'd0, rows_reg};
        if (nr > 9'(MAX_ROWS)) nr = 9'(MAX_ROWS);
    end

    function automatic logic [8:0] clampi(input logic [15:0] v, input logic [8:0] lim);
        logic [8:0] r;
        begin
            if (v[15]) r = 9'd0;
            else if (v >= {7'd0, lim}) r = lim - 9'd1;
            else r = v[8:0];
            return r;
        end
    endfunction

    logic [8:0]  ccol, crow;
    logic [17:0] cprod;
    always_comb
    begin
        if (it_reg.command == CMD_COUNT)
        begin
            ccol = clampi(it_reg.grid_col, nc);
            crow = clampi(it_reg.grid_row, nr);
        end
        else
        begin
            ccol = clampi(qx_reg, nc);
            crow = clampi(drsp.quotient, nr);
        end
        cprod = 18'(crow * nc) + {9'd0, ccol};
    end

    // fill count ram and bucket ram, both kinds side by side
    logic            f_we;
    logic [FAW-1:0]  f_addr;
    logic [NW-1:0]   f_wdata, f_rdata;
    logic            b_we;
    logic [AW-1:0]   b_addr;
    logic [ID_WIDTH-1:0] b_rdata;

    ugbs_ram #(.WIDTH(NW), .DEPTH(2 ** FAW)) u_fill (
        .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata)
    );
    ugbs_ram #(.WIDTH(ID_WIDTH), .DEPTH(2 ** AW)) u_bucket (
        .clk(clk), .we(b_we), .addr(b_addr), .wdata(it_reg.object_id[ID_WIDTH-1:0]),
        .rdata(b_rdata)
    );

    ugbs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [NW-1:0] nsat;
    assign nsat = (f_rdata > NW'(BUCKET_DEPTH)) ? NW'(BUCKET_DEPTH) : f_rdata;

    always_comb
    begin
        state_next      = state_reg;
        it_next         = it_reg;
        qx_next         = qx_reg;
        cell_next       = cell_reg;
        clr_next        = clr_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        res_next        = res_reg;
        ov_next         = ov_reg;
        done_after_next = done_after_reg;
        dreq            = '0;
        dreq.divisor    = cs_reg;
        f_we            = 1'b0;
        f_addr          = {it_reg.kind, cell_reg};
        f_wdata         = '0;
        b_we            = 1'b0;
        b_addr          = {it_reg.kind, cell_reg, k_reg[SW-1:0]};
        if (out_ch.ready) ov_next = 1'b0;
        case (state_reg)
            S_INIT, S_CLR:
            begin
                // sweep every fill counter address of both kinds
                f_we     = 1'b1;
                f_addr   = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    if (state_reg == S_CLR)
                    begin
                        res_next = '0;
                        res_next.last = 1'b1;
                        ov_next = 1'b1;
                        state_next = S_OUT;
                        done_after_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    it_next = in_ch.payload;
                    clr_next = '0;
                    case (in_ch.payload.command)
                        CMD_CLEAR: state_next = S_CLR;
                        CMD_COUNT: state_next = S_CELL;
                        default:
                        begin
                            dreq.start    = 1'b1;
                            dreq.dividend = in_ch.payload.pos_x;
                            state_next    = S_DIVX;
                        end
                    endcase
                end
            end
            S_DIVX:
            begin
                if (drsp.done)
                begin
                    qx_next       = drsp.quotient;
                    dreq.start    = 1'b1;
                    dreq.dividend = it_reg.pos_y;
                    state_next    = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (drsp.done)
                begin
                    cell_next  = (cprod >= 18'(CELLS)) ? CW'(CELLS - 1) : cprod[CW-1:0];
                    state_next = S_FRD;
                end
            end
            S_CELL:
            begin
                cell_next  = (cprod >= 18'(CELLS)) ? CW'(CELLS - 1) : cprod[CW-1:0];
                state_next = S_FRD;
            end
            S_FRD:
            begin
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                n_next = nsat;
                state_next = S_ACT;
            end
            S_ACT:
            begin
                res_next = '0;
                res_next.fill_count  = 5'(n_reg);
                res_next.cell_number = 8'(cell_reg);
                res_next.last        = 1'b1;
                k_next = '0;
                case (it_reg.command)
                    CMD_INSERT:
                    begin
                        if (n_reg >= NW'(BUCKET_DEPTH))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            b_we    = 1'b1;
                            b_addr  = {it_reg.kind, cell_reg, n_reg[SW-1:0]};
                            f_we    = 1'b1;
                            f_wdata = n_reg + 1'b1;
                            res_next.fill_count = 5'(n_reg + 1'b1);
                        end
                        ov_next = 1'b1;
                        done_after_next = 1'b1;
                        state_next = S_OUT;
                    end
                    CMD_QUERY:
                    begin
                        if (n_reg == '0)
                        begin
                            res_next.status = ST_EMPTY;
                            ov_next = 1'b1;
                            done_after_next = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_QRD;
                        end
                    end
                    default:
                    begin
                        ov_next = 1'b1;
                        done_after_next = 1'b1;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_QRD:
            begin
                state_next = S_QWAIT;
            end
            S_QWAIT:
            begin
                res_next.stored_id = 16'(b_rdata);
                res_next.last      = (k_reg + 1'b1 == n_reg);
                done_after_next    = res_next.last;
                ov_next            = 1'b1;
                state_next         = S_OUT;
            end
            S_OUT:
            begin
                // hold until the result transfer completes
                if (ov_reg && out_ch.ready)
                begin
                    if (done_after_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        b_addr     = {it_reg.kind, cell_reg, k_next[SW-1:0]};
                        state_next = S_QWAIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            clr_reg        <= '0;
            ov_reg         <= 1'b0;
            done_after_reg <= 1'b0;
            cs_reg         <= 12'd32;
            cols_reg       <= 5'd16;
            rows_reg       <= 5'd16;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            ov_reg         <= ov_next;
            done_after_reg <= done_after_next;
            if (cfg.valid)
            begin
                case (cfg.payload.index)
                    REG_CELL_SIZE: cs_reg   <= cfg.payload.data;
                    REG_COLUMNS:   cols_reg <= cfg.payload.data[4:0];
                    REG_ROWS:      rows_reg <= cfg.payload.data[4:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg   <= it_next;
        qx_reg   <= qx_next;
        cell_reg <= cell_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        res_reg  <= res_next;
    end

    assign cfg.ready      = 1'b1;
    assign in_ch.ready    = (state_reg == S_IDLE);
    assign out_ch.valid   = ov_reg;
    assign out_ch.payload = res_reg;
endmodule
`default_nettype wire
